[hdl/sparse_set_pair_store_assert.svh]
// Assertion macros used by the checker file of the sparse set store.
`ifndef SPARSE_SET_PAIR_STORE_ASSERT_SVH
`define SPARSE_SET_PAIR_STORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SPS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled during reset.
`define SPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

[hdl/sps_pkg.sv]
// Package: sequencer states and request kind codes of the sparse set store.
package sps_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_MOVE,
    ST_UNMAP,
    ST_HOLD
  } state_t;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

endpackage

[hdl/sps_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/sparse_set_pair_store.sv]
// Flow: a request is looked up in the map RAM (ST_LOOKUP); a remove that finds its id then
//   reads the last packed entry and makes two map writes (ST_MOVE, ST_UNMAP).
// The response is registered. Requests are taken only in ST_IDLE, one at a time.
// Reset: synchronous; afterwards a clearing pass writes every map entry with req_stall
//   high; config writes are taken during the pass.
// A held response (resp_stall) delays return to idle until the output register frees.
module sparse_set_pair_store #(
  parameter int ENTITY_COUNT = 1024,
  parameter int SLOT_DEPTH   = 1024
) (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         kind,
  input  logic [9:0]         entity_id,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  // response channel
  output logic               resp_valid,
  input  logic               resp_stall,
  output logic               ok,
  output logic [10:0]        count,
  // capacity register
  input  logic               cfg_we,
  input  logic [10:0]        cfg_wdata
);

  localparam int ID_W   = $clog2(ENTITY_COUNT);
  localparam int SLOT_W = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int CNT_W  = $clog2(SLOT_DEPTH + 1);
  localparam int MAP_W  = SLOT_W + 1;   // {present, slot}
  localparam int PK_W   = ID_W + 64;    // {owner, x, y}

  // Sequencer and request registers
  sps_pkg::state_t    state, state_next;
  logic [ID_W-1:0]    clr_addr, clr_addr_next;
  logic [1:0]         kind_q;
  logic [9:0]         id_q;
  logic signed [31:0] x_q, y_q;
  logic [SLOT_W-1:0]  slot_q, slot_q_next;
  logic [CNT_W-1:0]   entry_count, entry_count_next;
  logic [10:0]        cap_limit;
  logic               res_ok, res_ok_next;

  // Map RAM: entity id -> {present, slot}
  logic              map_we, map_re;
  logic [ID_W-1:0]   map_waddr, map_raddr;
  logic [MAP_W-1:0]  map_wdata, map_rdata;

  // Packed RAM: slot -> {owner, x, y}
  logic              pk_we, pk_re;
  logic [SLOT_W-1:0] pk_waddr, pk_raddr;
  logic [PK_W-1:0]   pk_wdata, pk_rdata;

  logic              finish, fin_ok, load_resp, out_free;
  logic              id_bad, full, map_hit;
  logic [SLOT_W-1:0] map_slot;
  logic [31:0]       eff_cap;

  sps_ram #(.WIDTH(MAP_W), .DEPTH(ENTITY_COUNT)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  sps_ram #(.WIDTH(PK_W), .DEPTH(SLOT_DEPTH)) u_packed_ram (
    .clk   (clk),
    .we    (pk_we),
    .waddr (pk_waddr),
    .wdata (pk_wdata),
    .re    (pk_re),
    .raddr (pk_raddr),
    .rdata (pk_rdata)
  );

  // Limit saturates at the built depth.
  assign eff_cap  = (32'(cap_limit) > SLOT_DEPTH) ? 32'(SLOT_DEPTH) : 32'(cap_limit);
  assign full     = 32'(entry_count) >= eff_cap;
  assign id_bad   = 32'(id_q) >= ENTITY_COUNT;
  assign map_hit  = map_rdata[SLOT_W];
  assign map_slot = map_rdata[SLOT_W-1:0];
  assign out_free = !resp_valid || !resp_stall;

  assign req_stall = (state != sps_pkg::ST_IDLE);

  always_comb begin
    state_next       = state;
    clr_addr_next    = clr_addr;
    slot_q_next      = slot_q;
    entry_count_next = entry_count;
    res_ok_next      = res_ok;
    finish           = 1'b0;
    fin_ok           = 1'b0;
    load_resp        = 1'b0;
    map_we           = 1'b0;
    map_waddr        = ID_W'(id_q);
    map_wdata        = '0;
    map_re           = 1'b0;
    map_raddr        = ID_W'(entity_id);
    pk_we            = 1'b0;
    pk_waddr         = slot_q;
    pk_wdata         = {ID_W'(id_q), x_q, y_q};
    pk_re            = 1'b0;
    pk_raddr         = SLOT_W'(entry_count - 1'b1);

    unique case (state)
      sps_pkg::ST_CLEAR: begin
        // sweep every map entry to "no slot"
        map_we        = 1'b1;
        map_waddr     = clr_addr;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == ID_W'(ENTITY_COUNT - 1)) begin
          state_next = sps_pkg::ST_IDLE;
        end
      end
      sps_pkg::ST_IDLE: begin
        map_re = 1'b1;
        if (req_valid) begin
          state_next = sps_pkg::ST_LOOKUP;
        end
      end
      sps_pkg::ST_LOOKUP: begin
        if (id_bad) begin
          finish = 1'b1;
        end else begin
          unique case (kind_q)
            sps_pkg::KIND_INSERT: begin
              finish = 1'b1;
              if (!full) begin
                fin_ok = 1'b1;
                pk_we  = 1'b1;
                if (map_hit) begin
                  pk_waddr = map_slot;   // update in place
                end else begin
                  // append at the end
                  pk_waddr         = SLOT_W'(entry_count);
                  map_we           = 1'b1;
                  map_wdata        = {1'b1, SLOT_W'(entry_count)};
                  entry_count_next = entry_count + 1'b1;
                end
              end
            end
            sps_pkg::KIND_REMOVE: begin
              if (map_hit) begin
                pk_re       = 1'b1;   // fetch the last packed entry
                slot_q_next = map_slot;
                state_next  = sps_pkg::ST_MOVE;
              end else begin
                finish = 1'b1;
              end
            end
            sps_pkg::KIND_QUERY: begin
              finish = 1'b1;
              fin_ok = map_hit;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      sps_pkg::ST_MOVE: begin
        // last entry into the freed slot, repoint its owner
        pk_we            = 1'b1;
        pk_waddr         = slot_q;
        pk_wdata         = pk_rdata;
        map_we           = 1'b1;
        map_waddr        = pk_rdata[PK_W-1 -: ID_W];
        map_wdata        = {1'b1, slot_q};
        entry_count_next = entry_count - 1'b1;
        state_next       = sps_pkg::ST_UNMAP;
      end
      sps_pkg::ST_UNMAP: begin
        // after the owner fix, so removing the last entry ends absent
        map_we    = 1'b1;
        map_waddr = ID_W'(id_q);
        map_wdata = '0;
        finish    = 1'b1;
        fin_ok    = 1'b1;
      end
      sps_pkg::ST_HOLD: begin
        if (out_free) begin
          load_resp  = 1'b1;
          fin_ok     = res_ok;
          state_next = sps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sps_pkg::ST_IDLE;
      end
    endcase

    if (finish) begin
      if (out_free) begin
        load_resp  = 1'b1;
        state_next = sps_pkg::ST_IDLE;
      end else begin
        res_ok_next = fin_ok;
        state_next  = sps_pkg::ST_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sps_pkg::ST_CLEAR;
      clr_addr    <= '0;
      entry_count <= '0;
      cap_limit   <= 11'd1024;
      resp_valid  <= 1'b0;
    end else begin
      state       <= state_next;
      clr_addr    <= clr_addr_next;
      entry_count <= entry_count_next;
      if (cfg_we) begin
        cap_limit <= cfg_wdata;
      end
      if (load_resp) begin
        resp_valid <= 1'b1;
      end else if (!resp_stall) begin
        resp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == sps_pkg::ST_IDLE && req_valid) begin
      kind_q <= kind;
      id_q   <= entity_id;
      x_q    <= pos_x;
      y_q    <= pos_y;
    end
    slot_q <= slot_q_next;
    res_ok <= res_ok_next;
    if (load_resp) begin
      ok    <= fin_ok;
      count <= 11'(entry_count_next);
    end
  end

endmodule

[hdl/sps_checker.sv]
// Port-level checker for the sparse set store, bound to the top level.
`include "sparse_set_pair_store_assert.svh"

module sps_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_stall,
  input logic        resp_valid,
  input logic        resp_stall,
  input logic        ok,
  input logic [10:0] count
);

  logic [10:0] last_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_count <= '0;
    end else if (resp_valid && !resp_stall) begin
      last_count <= count;
    end
  end

  // held response keeps its value
  `SPS_ASSERT_NEXT(a_resp_hold, clk, rst, resp_valid && resp_stall, resp_valid && $stable(ok) && $stable(count))
  // one request at a time
  `SPS_ASSERT_NEXT(a_one_at_a_time, clk, rst, req_valid && !req_stall, req_stall)
  // count moves by at most one per response
  `SPS_ASSERT_NOW(a_count_step, clk, rst, resp_valid && !resp_stall, (count == last_count) || (count == last_count + 11'd1) || (count + 11'd1 == last_count))
  // nothing pending straight out of reset
  `SPS_ASSERT_NOW(a_reset_quiet, clk, rst, $past(rst), !resp_valid && req_stall)

endmodule

bind sparse_set_pair_store sps_checker u_sps_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req_valid),
  .req_stall  (req_stall),
  .resp_valid (resp_valid),
  .resp_stall (resp_stall),
  .ok         (ok),
  .count      (count)
);

[test/testbench.sv]
// Testbench for sparse_set_pair_store: a directed table and random requests, checked by a map model.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Kind code 3 is unused by the block; it must change nothing.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam int ENTITIES    = 1024;
  localparam int SLOTS       = 1024;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 180;

  localparam logic [31:0] MINV = 32'h8000_0000;
  localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
  localparam logic [31:0] ONES = 32'hFFFF_FFFF;

  // What one response carries: the success flag and the packed count.
  typedef struct packed {
    logic        ok;
    logic [10:0] count;
  } resp_t;

  // One row of the directed table. wr: write the capacity limit before the
  // request. typed: the expected response is given in the row.
  typedef struct packed {
    logic        wr;
    logic [10:0] lim;
    logic [1:0]  k;
    logic [9:0]  id;
    logic [31:0] x;
    logic [31:0] y;
    logic        typed;
    logic        eok;
    logic [10:0] ecnt;
  } row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic [1:0]         kind = sps_pkg::KIND_QUERY;
  logic [9:0]         entity_id = '0;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_y = '0;
  logic               resp_valid;
  logic               resp_stall = 1'b0;
  logic               ok;
  logic [10:0]        count;
  logic               cfg_we = 1'b0;
  logic [10:0]        cfg_wdata = '0;

  // Map model. The x,y pairs never reach the response, so only the two
  // maps, the count and the limit are tracked.
  bit          present  [ENTITIES];
  logic [10:0] slot_of  [ENTITIES];
  logic [9:0]  owner_of [SLOTS];
  logic [10:0] live_count = '0;
  logic [10:0] limit_reg  = 11'd1024;

  resp_t pending_resp [$];
  int    mismatch_count = 0;
  int    cycle_count    = 0;
  bit    hold_off_req   = 1'b0;

  // Directed table: reset state, field extremes, update in place, swap on
  // remove, the unused kind, a full store (update of a present id rejected
  // too), zero limit, limit above depth, and limit lowered below the count.
  row_t plan [25] = '{
    '{1'b0, 11'd0,    sps_pkg::KIND_QUERY,  10'd0,    32'd0, 32'd0, 1'b1, 1'b0, 11'd0},
    '{1'b0, 11'd0,    sps_pkg::KIND_REMOVE, 10'd5,    32'd0, 32'd0, 1'b1, 1'b0, 11'd0},
    '{1'b0, 11'd0,    sps_pkg::KIND_INSERT, 10'd0,    MINV,  MAXV,  1'b1, 1'b1, 11'd1},
    '{1'b0, 11'd0,    sps_pkg::KIND_INSERT, 10'd1023, MAXV,  MINV,  1'b1, 1'b1, 11'd2},
    '{1'b0, 11'd0,    sps_pkg::KIND_INSERT, 10'd0,    32'd0, ONES,  1'b1, 1'b1, 11'd2},
    '{1'b0, 11'd0,    sps_pkg::KIND_QUERY,  10'd1023, ONES,  ONES,  1'b1, 1'b1, 11'd2},
    '{1'b0, 11'd0,    KIND_UNUSED,          10'd0,    ONES,  32'd0, 1'b1, 1'b0, 11'd2},
    '{1'b0, 11'd0,    sps_pkg::KIND_INSERT, 10'd512,  32'd5, ONES,  1'b0, 1'b0, 11'd0},
    '{1'b0, 11'd0,    sps_pkg::KIND_REMOVE, 10'd0,    32'd0, 32'd0, 1'b0, 1'b0, 11'd0},
    '{1'b0, 11'd0,    sps_pkg::KIND_QUERY,  10'd0,    32'd0, 32'd0, 1'b1, 1'b0, 11'd2},
    '{1'b0, 11'd0,    sps_pkg::KIND_REMOVE, 10'd512,  32'd0, 32'd0, 1'b0, 1'b0, 11'd0},
    '{1'b0, 11'd0,    sps_pkg::KIND_QUERY,  10'd1023, 32'd0, 32'd0, 1'b0, 1'b0, 11'd0},
    '{1'b1, 11'd1,    sps_pkg::KIND_INSERT, 10'd7,    32'd1, 32'd2, 1'b1, 1'b0, 11'd1},
    '{1'b0, 11'd0,    sps_pkg::KIND_INSERT, 10'd1023, 32'd3, 32'd4, 1'b1, 1'b0, 11'd1},
    '{1'b0, 11'd0,    sps_pkg::KIND_REMOVE, 10'd1023, 32'd0, 32'd0, 1'b1, 1'b1, 11'd0},
    '{1'b0, 11'd0,    sps_pkg::KIND_INSERT, 10'd7,    MAXV,  MAXV,  1'b0, 1'b0, 11'd0},
    '{1'b0, 11'd0,    sps_pkg::KIND_INSERT, 10'd8,    MINV,  MINV,  1'b1, 1'b0, 11'd1},
    '{1'b1, 11'd0,    sps_pkg::KIND_INSERT, 10'd9,    32'd9, 32'd9, 1'b1, 1'b0, 11'd1},
    '{1'b0, 11'd0,    sps_pkg::KIND_QUERY,  10'd7,    32'd0, 32'd0, 1'b1, 1'b1, 11'd1},
    '{1'b0, 11'd0,    sps_pkg::KIND_REMOVE, 10'd7,    32'd0, 32'd0, 1'b1, 1'b1, 11'd0},
    '{1'b1, 11'd2047, sps_pkg::KIND_INSERT, 10'd3,    32'd7, ONES,  1'b1, 1'b1, 11'd1},
    '{1'b0, 11'd0,    sps_pkg::KIND_INSERT, 10'd4,    ONES,  32'd7, 1'b1, 1'b1, 11'd2},
    '{1'b1, 11'd1,    sps_pkg::KIND_INSERT, 10'd5,    32'd0, 32'd0, 1'b1, 1'b0, 11'd2},
    '{1'b0, 11'd0,    sps_pkg::KIND_QUERY,  10'd4,    32'd0, 32'd0, 1'b1, 1'b1, 11'd2},
    '{1'b0, 11'd0,    sps_pkg::KIND_REMOVE, 10'd3,    32'd0, 32'd0, 1'b1, 1'b1, 11'd1}
  };

  sparse_set_pair_store DUT (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .kind       (kind),
    .entity_id  (entity_id),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .resp_valid (resp_valid),
    .resp_stall (resp_stall),
    .ok         (ok),
    .count      (count),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one accepted request to the map model and returns the response.
  function automatic resp_t apply_request(input logic [1:0] k, input logic [9:0] id);
    resp_t       r;
    logic [10:0] cap;
    logic [10:0] hole;
    logic [10:0] last;
    logic [9:0]  moved;
    cap  = (limit_reg > SLOTS) ? 11'(SLOTS) : limit_reg;
    r.ok = 1'b0;
    case (k)
      sps_pkg::KIND_INSERT: begin
        // A full store rejects every insert, updates of present ids included.
        if (live_count < cap) begin
          r.ok = 1'b1;
          if (!present[id]) begin
            owner_of[live_count] = id;
            slot_of[id]          = live_count;
            present[id]          = 1'b1;
            live_count           = live_count + 1'b1;
          end
        end
      end
      sps_pkg::KIND_REMOVE: begin
        // The last packed entry fills the hole; its owner's slot follows it.
        if (present[id]) begin
          hole           = slot_of[id];
          last           = live_count - 1'b1;
          moved          = owner_of[last];
          owner_of[hole] = moved;
          slot_of[moved] = hole;
          present[id]    = 1'b0;
          slot_of[id]    = '0;
          live_count     = last;
          r.ok           = 1'b1;
        end
      end
      sps_pkg::KIND_QUERY: r.ok = present[id];
      default: ;
    endcase
    r.count = live_count;
    return r;
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Offers one request, waits for the handshake, records what should come back.
  task automatic issue(input logic [1:0] k, input logic [9:0] id,
                       input logic [31:0] x, input logic [31:0] y,
                       input logic typed, input logic eok, input logic [10:0] ecnt);
    resp_t r;
    req_valid <= 1'b1;
    kind      <= k;
    entity_id <= id;
    pos_x     <= x;
    pos_y     <= y;
    do @(posedge clk); while (req_stall);
    r = apply_request(k, id);
    if (typed) begin
      r.ok    = eok;
      r.count = ecnt;
    end
    pending_resp.push_back(r);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      req_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Limit writes happen only with nothing in flight: the task waits until no response
  // is outstanding and then lets the block settle in idle before the write.
  task automatic set_limit(input logic [10:0] v);
    req_valid <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_reg = v;
  endtask

  // Request side: directed table, then random phases at several limits.
  initial begin
    logic [10:0] phase_limit [7];
    logic [9:0]  base;
    logic [1:0]  k;
    logic [9:0]  id;
    int          r;
    bit          calm;
    phase_limit = '{11'd2047, 11'd16, 11'd1, 11'd0, 11'd1024, 11'd0, 11'd3};
    phase_limit[5] = 11'($urandom_range(2, 64));
    calm = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // The clearing pass after reset shows up as req_stall; issue waits it out.
    foreach (plan[i]) begin
      if (plan[i].wr) set_limit(plan[i].lim);
      issue(plan[i].k, plan[i].id, plan[i].x, plan[i].y,
            plan[i].typed, plan[i].eok, plan[i].ecnt);
      pause($urandom_range(0, 1));
    end

    for (int p = 0; p < 7; p++) begin
      set_limit(phase_limit[p]);
      base = 10'($urandom_range(0, ENTITIES - 1));
      // Long receiver hold-off early on so the block backs up into req_stall.
      if (p == 0) hold_off_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 50 == 0) calm = ($urandom_range(0, 4) == 0);
        r = $urandom_range(0, 19);
        if (r < 9)       k = sps_pkg::KIND_INSERT;
        else if (r < 15) k = sps_pkg::KIND_REMOVE;
        else if (r < 19) k = sps_pkg::KIND_QUERY;
        else             k = KIND_UNUSED;
        // Ids mostly from a small window or from entries already stored, so
        // removes and updates hit; the rest span the whole id range.
        r = $urandom_range(0, 9);
        if (r < 5)
          id = base + 10'($urandom_range(0, 31));
        else if (r < 8 && live_count != 0)
          id = owner_of[$urandom_range(0, live_count - 1)];
        else
          id = 10'($urandom_range(0, ENTITIES - 1));
        issue(k, id, $urandom, $urandom, 1'b0, 1'b0, 11'd0);
        if (!calm) pause(idle_len());
      end
    end

    req_valid <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Response side: random stalls, stall-free stretches, and one long hold.
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        resp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        resp_stall <= 1'b0;
        @(posedge clk);
      end else if ($urandom_range(0, 7) == 0) begin
        resp_stall <= 1'b0;
        repeat (100) @(posedge clk);
      end else begin
        n = idle_len();
        if (n > 0) begin
          resp_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        resp_stall <= 1'b0;
        repeat (1 + $urandom_range(0, 3)) @(posedge clk);
      end
    end
  end

  // Each taken response is matched against the oldest expectation.
  always @(posedge clk) begin
    resp_t want;
    if (!rst && resp_valid && !resp_stall) begin
      if (pending_resp.size() == 0) begin
        $error("response with no request outstanding: ok=%0b count=%0d", ok, count);
        mismatch_count++;
      end else begin
        want = pending_resp.pop_front();
        if (ok !== want.ok) begin
          $error("ok: expected %0b, got %0b", want.ok, ok);
          mismatch_count++;
        end
        if (count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, count);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
